>>> rtl/ssdf_pkg.sv
// Shared constants, types and the segment decoder of the display command framer.
package ssdf_pkg;

    localparam int DIGITS = 4;
    localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int K_W = DIG_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam bit POINT_ENABLED = (DIGITS >= 3);

    localparam logic [2:0] OP_INT = 3'd0;
    localparam logic [2:0] OP_FIXED = 3'd1;
    localparam logic [2:0] OP_ON = 3'd2;
    localparam logic [2:0] OP_OFF = 3'd3;
    localparam logic [2:0] OP_INIT = 3'd4;

    localparam logic [7:0] ADDR_BASE = 8'hC0;
    localparam logic [7:0] CMD_ON_BYTE = 8'h8F;
    localparam logic [7:0] CMD_OFF_BYTE = 8'h80;
    localparam logic [7:0] CMD_MODE_BYTE = 8'h44;
    localparam logic [7:0] SEG_POINT = 8'h80;

    typedef enum logic [1:0] {
        KIND_SHOW,
        KIND_ON,
        KIND_OFF,
        KIND_INIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic                      point;
        logic [DIGITS-1:0][3:0]    digits;
    } entry_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0: seg = 8'h3f;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5b;
            4'd3: seg = 8'h4f;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6d;
            4'd6: seg = 8'h7d;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7f;
            4'd9: seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/ssdf_if.sv
// Handshake interfaces for the command channel and the frame byte channel.
interface ssdf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface ssdf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;

    modport source (output valid, output frame_byte, output frame_start,
                    output frame_end, output last, input ready);
    modport sink (input valid, input frame_byte, input frame_start,
                  input frame_end, input last, output ready);
endinterface

>>> rtl/seven_segment_display_command_framer_core.sv
// Top level of the display command framer: front end, command queue and byte sequencer.
// Usage: commands arrive on the cmd channel (op, value) and frame bytes leave on the frame
// channel, each word carrying frame_byte, frame_start, frame_end and last. A word moves at
// a rising edge at which valid and ready are both high.
// Ops 0 and 1 produce eight words at four digits (address byte, then segment byte, from the
// ones digit at the highest address down to address 0). Op 2 and op 3 give one word, op 4
// gives two, and op codes 5 to 7 are taken and give nothing.
// A display command is converted to decimal one digit at a time in the front end, then
// passes the queue, the byte sequencer and its output register; on, off and init commands
// skip the conversion and go straight to the queue.
// Throughput: the byte sequencer emits one word a cycle while the receiver takes them;
// the front end converts the next command meanwhile and the two-entry queue holds
// finished ones.
// Reset clears the queue, the sequencer and the output register; no word is valid after it.
// When the receiver stalls, the output register holds its word, the sequencer waits, the
// queue fills and the front end then stops taking commands.
module seven_segment_display_command_framer_core (
    input  logic         clk,
    input  logic         rst_n,
    ssdf_cmd_if.sink     cmd,
    ssdf_frame_if.source frame
);
    import ssdf_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    ssdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ssdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ssdf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .frame   (frame)
    );

endmodule

>>> rtl/ssdf_front.sv
// Front end: accepts commands, classifies them and converts values to decimal digits.
module ssdf_front (
    input  logic            clk,
    input  logic            rst_n,
    ssdf_cmd_if.sink        cmd,
    output logic            push_valid,
    input  logic            push_ready,
    output ssdf_pkg::entry_t push_data
);
    import ssdf_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [15:0]       val_reg, val_next;
    logic [DIG_W-1:0]  cnt_reg, cnt_next;
    entry_t            entry_reg, entry_next;

    logic              accept;
    logic [31:0]       product;
    logic [15:0]       quot;
    logic [15:0]       times_ten;
    logic [3:0]        rem;

    // Division by ten through the reciprocal, exact over the whole 16-bit range.
    assign product = 32'(val_reg) * 32'd52429;
    assign quot = 16'(product >> 19);
    assign times_ten = 16'(quot << 3) + 16'(quot << 1);
    assign rem = 4'(val_reg - times_ten);

    assign cmd.ready = (state_reg == F_IDLE) || ((state_reg == F_PUSH) && push_ready);
    assign accept = cmd.valid && cmd.ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_data = entry_reg;

    always_comb
    begin
        state_next = state_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        entry_next = entry_reg;
        if (state_reg == F_CONV)
        begin
            entry_next.digits[cnt_reg] = rem;
            val_next = quot;
            if (cnt_reg == DIG_W'(DIGITS - 1))
            begin
                state_next = F_PUSH;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if ((state_reg == F_PUSH) && push_ready)
        begin
            state_next = F_IDLE;
        end
        if (accept)
        begin
            unique case (cmd.op) inside
                OP_INT, OP_FIXED:
                begin
                    state_next = F_CONV;
                    val_next = cmd.value;
                    cnt_next = '0;
                    entry_next.kind = KIND_SHOW;
                    entry_next.point = (cmd.op == OP_FIXED);
                end
                OP_ON:
                begin
                    state_next = F_PUSH;
                    entry_next.kind = KIND_ON;
                    entry_next.point = 1'b0;
                end
                OP_OFF:
                begin
                    state_next = F_PUSH;
                    entry_next.kind = KIND_OFF;
                    entry_next.point = 1'b0;
                end
                OP_INIT:
                begin
                    state_next = F_PUSH;
                    entry_next.kind = KIND_INIT;
                    entry_next.point = 1'b0;
                end
                default:
                begin
                    state_next = F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        entry_reg <= entry_next;
    end

    a_conv_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV && cnt_reg != DIG_W'(DIGITS - 1)) |=>
            (state_reg == F_CONV && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("digit conversion left early");

    a_conv_ends_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV && cnt_reg == DIG_W'(DIGITS - 1)) |=> (state_reg == F_PUSH))
        else $error("digit conversion did not hand over its word");

    a_no_accept_while_converting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV) |-> !cmd.ready)
        else $error("command taken during conversion");

endmodule

>>> rtl/ssdf_queue.sv
// Short queue of classified commands between the front end and the byte sequencer.
module ssdf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ssdf_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ssdf_pkg::entry_t pop_data
);
    import ssdf_pkg::*;

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a word on push");

    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue miscounted a pop");

endmodule

>>> rtl/ssdf_back.sv
// Back end: expands each queued command into its frame bytes, one byte per cycle unless the receiver stalls.
module ssdf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  ssdf_pkg::entry_t q_data,
    ssdf_frame_if.source     frame
);
    import ssdf_pkg::*;

    entry_t            cur_reg;
    logic              busy_reg;
    logic [K_W-1:0]    k_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_start_reg;
    logic              out_end_reg;
    logic              out_last_reg;

    logic              advance;
    logic              is_last;
    logic              pop;
    logic [K_W-1:0]    last_k;
    logic [DIG_W-1:0]  d;
    logic [5:0]        addr;
    logic [7:0]        seg;
    logic [7:0]        byte_val;
    logic              start_val;
    logic              end_val;

    assign advance = !out_valid_reg || frame.ready;
    assign is_last = busy_reg && (k_reg == last_k);
    assign pop = q_valid && (!busy_reg || (advance && is_last));
    assign q_ready = pop;

    assign frame.valid = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_start = out_start_reg;
    assign frame.frame_end = out_end_reg;
    assign frame.last = out_last_reg;

    // Digit zero is the ones digit, which sits at the highest address.
    assign d = k_reg[K_W-1:1];
    assign addr = 6'(DIGITS - 1) - 6'(d);

    always_comb
    begin
        seg = seg_code(cur_reg.digits[d]);
        if (POINT_ENABLED && cur_reg.point && (d == DIG_W'(2)))
        begin
            seg = seg | SEG_POINT;
        end
        unique case (cur_reg.kind)
            KIND_SHOW:
            begin
                last_k = K_W'(2 * DIGITS - 1);
                byte_val = k_reg[0] ? seg : (ADDR_BASE + 8'({2'b00, addr}));
                start_val = !k_reg[0];
                end_val = k_reg[0];
            end
            KIND_ON:
            begin
                last_k = '0;
                byte_val = CMD_ON_BYTE;
                start_val = 1'b1;
                end_val = 1'b1;
            end
            KIND_OFF:
            begin
                last_k = '0;
                byte_val = CMD_OFF_BYTE;
                start_val = 1'b1;
                end_val = 1'b1;
            end
            KIND_INIT:
            begin
                last_k = K_W'(1);
                byte_val = k_reg[0] ? CMD_ON_BYTE : CMD_MODE_BYTE;
                start_val = 1'b1;
                end_val = 1'b1;
            end
            default:
            begin
                last_k = '0;
                byte_val = '0;
                start_val = 1'b0;
                end_val = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (advance && is_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_val;
            out_start_reg <= start_val;
            out_end_reg <= end_val;
            out_last_reg <= is_last;
        end
        if (pop)
        begin
            cur_reg <= q_data;
            k_reg <= '0;
        end
        else if (advance && busy_reg)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= last_k))
        else $error("byte index past the end of its command");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && busy_reg && !is_last && !pop) |=>
            (busy_reg && k_reg == $past(k_reg) + 1'b1))
        else $error("byte sequencer skipped or repeated a byte");

    a_new_command_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (busy_reg && k_reg == '0))
        else $error("new command did not start at its first byte");

    a_output_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame.ready) |=> (out_valid_reg && $stable(out_byte_reg)))
        else $error("stalled frame byte changed");

endmodule
